// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, a, b)
`define ASSERT_NEXT(label, a, b)
`endif
`endif

// ===== hw/rtl/rau_pkg.sv =====
// Package for the rational arithmetic unit: action codes, shared types.
// No dependencies.
package rau_pkg;
  typedef enum logic [3:0] {
    ACT_ADD = 4'd0, ACT_SUB = 4'd1, ACT_MUL = 4'd2, ACT_DIV = 4'd3,
    ACT_LT = 4'd4, ACT_GT = 4'd5, ACT_LE = 4'd6, ACT_GE = 4'd7,
    ACT_EQ = 4'd8, ACT_NE = 4'd9
  } act_t;

  typedef enum logic [1:0] {
    CLS_ARITH = 2'd0, CLS_CMP = 2'd1, CLS_NONE = 2'd2
  } cls_t;

  typedef enum logic [2:0] {
    GS_IDLE, GS_SHIFT, GS_SUB, GS_DIV, GS_DONE
  } gcd_state_t;

  typedef enum logic [4:0] {
    BS_IDLE, BS_A_START, BS_A_WAIT, BS_B_START, BS_B_WAIT, BS_CMP_MUL,
    BS_CMP_DONE, BS_ADD_D_START, BS_ADD_D_WAIT, BS_ADD_MUL1, BS_ADD_MUL2,
    BS_ADD_MUL3, BS_ADD_R_START, BS_ADD_R_WAIT, BS_MUL_X_START, BS_MUL_X_WAIT,
    BS_MUL_Y_START, BS_MUL_Y_WAIT, BS_MUL_PROD, BS_DIV_B_START, BS_DIV_B_WAIT,
    BS_OUT
  } back_state_t;
endpackage

// ===== hw/rtl/rau_gcd_reduce.sv =====
// Iterative reduction of n/d: binary gcd, then restoring division by gcd.
// Depends on rau_pkg.
module rau_gcd_reduce import rau_pkg::*; #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] n,
  input  logic [W-1:0] d,
  output logic         done,
  output logic [W-1:0] rn,
  output logic [W-1:0] rd
);
  localparam int CW = $clog2(W + 1);

  gcd_state_t state, state_next;
  logic [W-1:0] u, v, qn, qd, remn, remd, g, n_mag, d_mag;
  logic [CW-1:0] sh, bitc;
  logic neg_n, neg_d, special, bypass;
  logic [W:0] tn, td;

  // zero denominator, zero numerator, equal or opposite parts short-cut
  assign n_mag   = n[W-1] ? -n : n;
  assign d_mag   = d[W-1] ? -d : d;
  assign special = d == '0 || n == '0 || n == d || n == -d;

  always_comb begin
    state_next = state;
    unique case (state)
      GS_IDLE:  if (start) state_next = special ? GS_DONE : GS_SHIFT;
      GS_SHIFT: if (u[0] || v[0]) state_next = GS_SUB;
      GS_SUB:   if (v == '0) state_next = GS_DIV;
      GS_DIV:   if (bitc == CW'(W - 1)) state_next = GS_DONE;
      GS_DONE:  state_next = GS_IDLE;
      default:  state_next = GS_IDLE;
    endcase
  end

  assign g  = u << sh;
  assign tn = {remn, qn[W-1]} - {1'b0, g};
  assign td = {remd, qd[W-1]} - {1'b0, g};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= GS_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= state == GS_DONE;
      unique case (state)
        GS_IDLE: if (start) begin
          neg_n  <= n[W-1];
          neg_d  <= d[W-1];
          u      <= n_mag;
          v      <= d_mag;
          qn     <= n_mag;
          qd     <= d_mag;
          remn   <= '0;
          remd   <= '0;
          sh     <= '0;
          bitc   <= '0;
          bypass <= special;
          if (d == '0 || n == '0) begin
            rn <= '0; rd <= W'(1);
          end else if (n == d) begin
            rn <= W'(1); rd <= W'(1);
          end else if (n == -d) begin
            rn <= '1; rd <= W'(1);
          end
        end
        GS_SHIFT: if (!(u[0] || v[0])) begin
          u  <= u >> 1;
          v  <= v >> 1;
          sh <= sh + 1'b1;
        end
        GS_SUB: if (v != '0) begin
          if (!u[0]) u <= u >> 1;
          else if (!v[0]) v <= v >> 1;
          else if (u > v) u <= (u - v) >> 1;
          else v <= (v - u) >> 1;
        end
        GS_DIV: begin
          remn <= tn[W] ? {remn[W-2:0], qn[W-1]} : tn[W-1:0];
          remd <= td[W] ? {remd[W-2:0], qd[W-1]} : td[W-1:0];
          qn   <= {qn[W-2:0], ~tn[W]};
          qd   <= {qd[W-2:0], ~td[W]};
          bitc <= bitc + 1'b1;
        end
        GS_DONE: if (!bypass) begin
          rn <= neg_n ? -qn : qn;
          rd <= neg_d ? -qd : qd;
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== hw/rtl/rau_front.sv =====
// Front end: accepts words, classifies the action, queues them.
// Depends on rau_pkg.
module rau_front import rau_pkg::*; #(
  parameter int W = 32,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [3:0]       in_act,
  input  logic [4*W-1:0]   in_ops,
  output logic             q_valid,
  input  logic             q_ready,
  output logic [3:0]       q_act,
  output cls_t             q_cls,
  output logic [4*W-1:0]   q_ops
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [3:0]     mem_act [DEPTH];
  cls_t           mem_cls [DEPTH];
  logic [4*W-1:0] mem_ops [DEPTH];
  logic [AW-1:0]  wp, rp;
  logic [AW:0]    cnt;
  cls_t           cls;

  always_comb begin
    case (in_act) inside
      ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: cls = CLS_ARITH;
      ACT_LT, ACT_GT, ACT_LE, ACT_GE, ACT_EQ, ACT_NE: cls = CLS_CMP;
      default: cls = CLS_NONE;
    endcase
  end

  assign in_ready = cnt != (AW+1)'(DEPTH);
  assign q_valid  = cnt != '0;
  assign q_act    = mem_act[rp];
  assign q_cls    = mem_cls[rp];
  assign q_ops    = mem_ops[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mem_act[wp] <= in_act;
      mem_cls[wp] <= cls;
      mem_ops[wp] <= in_ops;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (in_valid && in_ready)
        wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      if (q_valid && q_ready)
        rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(in_valid && in_ready) - (AW+1)'(q_valid && q_ready);
    end
  end
endmodule

// ===== hw/rtl/rau_back.sv =====
// Back end: sequencer over one shared reducer; products wrap at W bits.
// Depends on rau_pkg and rau_gcd_reduce.
module rau_back import rau_pkg::*; #(
  parameter int W = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  logic [3:0]     q_act,
  input  cls_t           q_cls,
  input  logic [4*W-1:0] q_ops,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [W-1:0]   out_num,
  output logic [W-1:0]   out_den,
  output logic           out_truth
);
  back_state_t state, state_next;
  logic [3:0] act;
  cls_t cls;
  logic [W-1:0] an, ad, bn, bd, t0, t1, t2, t3, rn_r, rd_r;
  logic truth_r;
  logic g_start, g_done;
  logic [W-1:0] g_n, g_d, g_rn, g_rd;
  logic [W-1:0] m_x, m_y, m_p;
  logic eq, lt, gt;

  rau_gcd_reduce #(.W(W)) u_red (
    .clk(clk), .rst(rst), .start(g_start), .n(g_n), .d(g_d),
    .done(g_done), .rn(g_rn), .rd(g_rd)
  );

  assign m_p = W'(m_x * m_y);

  always_comb begin
    state_next = state;
    unique case (state)
      BS_IDLE:        if (q_valid) state_next = BS_A_START;
      BS_A_START:     state_next = BS_A_WAIT;
      BS_A_WAIT:      if (g_done) state_next = BS_B_START;
      BS_B_START:     state_next = BS_B_WAIT;
      BS_B_WAIT: if (g_done) begin
        if (cls != CLS_ARITH) state_next = BS_CMP_MUL;
        else if (act == ACT_ADD || act == ACT_SUB) state_next = BS_ADD_D_START;
        else if (act == ACT_MUL) state_next = BS_MUL_X_START;
        else state_next = BS_DIV_B_START;
      end
      BS_CMP_MUL:     state_next = BS_CMP_DONE;
      BS_CMP_DONE:    state_next = BS_OUT;
      BS_ADD_D_START: state_next = BS_ADD_D_WAIT;
      BS_ADD_D_WAIT:  if (g_done) state_next = BS_ADD_MUL1;
      BS_ADD_MUL1:    state_next = BS_ADD_MUL2;
      BS_ADD_MUL2:    state_next = BS_ADD_MUL3;
      BS_ADD_MUL3:    state_next = BS_ADD_R_START;
      BS_ADD_R_START: state_next = BS_ADD_R_WAIT;
      BS_ADD_R_WAIT:  if (g_done) state_next = BS_OUT;
      BS_DIV_B_START: state_next = BS_DIV_B_WAIT;
      BS_DIV_B_WAIT:  if (g_done) state_next = BS_MUL_X_START;
      BS_MUL_X_START: state_next = BS_MUL_X_WAIT;
      BS_MUL_X_WAIT:  if (g_done) state_next = BS_MUL_Y_START;
      BS_MUL_Y_START: state_next = BS_MUL_Y_WAIT;
      BS_MUL_Y_WAIT:  if (g_done) state_next = BS_MUL_PROD;
      BS_MUL_PROD:    state_next = BS_OUT;
      BS_OUT:         if (!out_valid || out_ready) state_next = BS_IDLE;
      default:        state_next = BS_IDLE;
    endcase
  end

  always_comb begin
    q_ready = state == BS_IDLE;
    g_start = 1'b0;
    g_n = an;
    g_d = ad;
    m_x = an;
    m_y = bd;
    unique case (state)
      BS_A_START: g_start = 1'b1;
      BS_B_START: begin g_start = 1'b1; g_n = bn; g_d = bd; end
      BS_ADD_D_START: begin g_start = 1'b1; g_n = ad; g_d = bd; end
      BS_ADD_R_START: begin g_start = 1'b1; g_n = t0; g_d = t1; end
      BS_DIV_B_START: begin g_start = 1'b1; g_n = bd; g_d = bn; end
      BS_MUL_X_START: begin g_start = 1'b1; g_n = bn; g_d = ad; end
      BS_MUL_Y_START: begin g_start = 1'b1; g_n = an; g_d = bd; end
      BS_CMP_MUL: begin m_x = an; m_y = bd; end
      BS_CMP_DONE: begin m_x = ad; m_y = bn; end
      BS_ADD_MUL1: begin m_x = ad; m_y = t1; end
      BS_ADD_MUL2: begin m_x = an; m_y = t1; end
      BS_ADD_MUL3: begin m_x = bn; m_y = t0; end
      BS_MUL_PROD: begin m_x = t0; m_y = t2; end
      default: ;
    endcase
  end

  assign eq = an == bn && ad == bd;
  assign lt = $signed(t3) < $signed(m_p);
  assign gt = $signed(m_p) < $signed(t3);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BS_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BS_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      BS_IDLE: if (q_valid) begin
        act <= q_act; cls <= q_cls;
        an <= q_ops[W-1:0]; ad <= q_ops[2*W-1:W];
        bn <= q_ops[3*W-1:2*W]; bd <= q_ops[4*W-1:3*W];
        rn_r <= '0; rd_r <= W'(1); truth_r <= 1'b0;
      end
      BS_A_START: if (ad == '0) begin an <= '0; ad <= W'(1); end
      BS_A_WAIT: if (g_done) begin an <= g_rn; ad <= g_rd; end
      BS_B_START: if (bd == '0) begin bn <= '0; bd <= W'(1); end
      BS_B_WAIT: if (g_done) begin
        bn <= (act == ACT_SUB) ? -g_rn : g_rn; bd <= g_rd;
      end
      BS_CMP_MUL: t3 <= m_p;
      BS_CMP_DONE: begin
        unique case (act)
          ACT_LT: truth_r <= lt;
          ACT_GT: truth_r <= gt;
          ACT_LE: truth_r <= lt || eq;
          ACT_GE: truth_r <= gt || eq;
          ACT_EQ: truth_r <= eq;
          ACT_NE: truth_r <= !eq;
          default: truth_r <= 1'b0;
        endcase
      end
      BS_ADD_D_WAIT: if (g_done) begin t0 <= g_rn; t1 <= g_rd; end
      BS_ADD_MUL1: t2 <= m_p;
      BS_ADD_MUL2: t3 <= m_p;
      BS_ADD_MUL3: begin t0 <= t3 + m_p; t1 <= t2; end
      BS_ADD_R_START: if (t1 == '0) begin rn_r <= '0; rd_r <= W'(1); end
      BS_ADD_R_WAIT: if (g_done && t1 != '0) begin rn_r <= g_rn; rd_r <= g_rd; end
      BS_DIV_B_START: if (bn == '0) begin bn <= '0; bd <= W'(1); end
      BS_DIV_B_WAIT: if (g_done) begin bn <= g_rn; bd <= g_rd; end
      BS_MUL_X_START: if (ad == '0) begin t0 <= '0; t1 <= W'(1); end
      BS_MUL_X_WAIT: if (g_done) begin t0 <= g_rn; t1 <= g_rd; end
      BS_MUL_Y_START: if (bd == '0) begin t2 <= '0; t3 <= W'(1); end
      BS_MUL_Y_WAIT: if (g_done) begin t2 <= g_rn; t3 <= g_rd; end
      BS_MUL_PROD: begin
        if (W'(t1 * t3) == '0) begin
          rn_r <= '0; rd_r <= W'(1);
        end else begin
          rn_r <= m_p; rd_r <= W'(t1 * t3);
        end
      end
      BS_OUT: if (!out_valid || out_ready) begin
        out_num <= rn_r; out_den <= rd_r; out_truth <= truth_r;
      end
      default: ;
    endcase
  end
endmodule

// ===== hw/rtl/rational_arith_unit_top.sv =====
// Rational arithmetic unit: takes two fractions and an action per word and
// returns one reduced fraction or a truth bit. Items run one at a time on a
// shared reducer: a reduction strips the common factors of two, runs binary
// gcd steps, divides both parts by the gcd, and is short-cut in a zero or
// equal/opposite-parts case. A compare runs two reductions, add, subtract
// and multiply four, divide five, plus sequencing states; a two-entry queue
// lets the next word in while the back end works and the result waits in
// the output register.
module rational_arith_unit_top import rau_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // action, a_num, a_den, b_num, b_den (from bit 0)
  input  logic [(4*VALUE_BITS+11)/8*8-1:0]   s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // res_num, res_den, truth (from bit 0)
  output logic [(2*VALUE_BITS+8)/8*8-1:0]    m_tdata
);
  localparam int W = VALUE_BITS;
  localparam int OUT_PAD = (2*W+8)/8*8 - 2*W - 1;

  logic q_valid, q_ready;
  logic [3:0] q_act;
  cls_t q_cls;
  logic [4*W-1:0] q_ops;
  logic [W-1:0] rnum, rden;
  logic rtruth;

  rau_front #(.W(W), .DEPTH(2)) u_front (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .in_act(s_tdata[3:0]), .in_ops(s_tdata[4*W+3:4]),
    .q_valid(q_valid), .q_ready(q_ready), .q_act(q_act), .q_cls(q_cls),
    .q_ops(q_ops)
  );

  rau_back #(.W(W)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready),
    .q_act(q_act), .q_cls(q_cls), .q_ops(q_ops),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_num(rnum), .out_den(rden), .out_truth(rtruth)
  );

  assign m_tdata = {{OUT_PAD{1'b0}}, rtruth, rden, rnum};

  `include "assert_macros.svh"
  `ASSERT_IMPLIES(a_truth_cmp_only, m_tvalid && rtruth, rnum == '0 && rden == W'(1))
  `ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid)
  `ASSERT_IMPLIES(a_den_nonzero, m_tvalid, rden != '0)
endmodule
